@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the encoder angle decoder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");

// condition implies consequence in the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");

`endif

@@ rtl/core/ead_pkg.sv @@
// Package for the encoder angle decoder: modes, register indexes, constants
// and the sideband struct carried alongside each item. No dependencies.
package ead_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int CNT_W     = 40;     // integer bits of angle numerator
    localparam int DVS_W     = 31;     // divisor width
    localparam int SPEED_W   = 30;
    localparam int GAIN_W    = 24;
    localparam int SPEED_K   = 11250;  // 360*1000*256/8192
    localparam int DEG_TURN  = 360;
    localparam int ABS_DIV   = 16383;
    localparam int K_PWM12   = 4097;
    localparam int K_PWM10   = 1025;
    localparam int SH_PWM12  = 12;
    localparam int SH_PWM10  = 10;
    localparam int HI_LIM    = 32768;  // hi partial product overflow limit
    localparam logic signed [31:0] ANG_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ANG_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        MODE_QUAD  = 2'd0,
        MODE_ABS14 = 2'd1,
        MODE_PWM12 = 2'd2,
        MODE_PWM10 = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_GAIN   = 2'd1,
        REG_OFFSET = 2'd2,
        REG_TPR    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                      neg;     // sign of raw angle
        logic                      zmag;    // force raw magnitude to zero
        logic                      bypass;  // zero PWM period: angle is zero
        logic signed [SPEED_W-1:0] speed;
        logic [7:0]                err;
    } t_side;

endpackage

@@ rtl/core/ead_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, sideband carried.
// Depends on ead_pkg (t_side, DVS_W).
module ead_div #(
    parameter int DW = 56,
    parameter int VW = ead_pkg::DVS_W
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  ead_pkg::t_side  i_side,
    input  logic [DW-1:0]   i_dvd,
    input  logic [VW-1:0]   i_dvs,
    output logic            o_valid,
    output ead_pkg::t_side  o_side,
    output logic [DW-1:0]   o_quo
);
    import ead_pkg::*;

    logic          r_vld  [DW];
    t_side         r_side [DW];
    logic [VW-1:0] r_dvs  [DW];
    logic [VW-1:0] r_rem  [DW];
    logic [DW-1:0] r_dq   [DW];

    for (genvar s = 0; s < DW; s++) begin : g_stg
        logic          w_vld_in;
        t_side         w_side_in;
        logic [VW-1:0] w_dvs_in;
        logic [VW-1:0] w_rem_in;
        logic [DW-1:0] w_dq_in;
        logic [VW:0]   w_t;
        logic [VW:0]   w_d;
        logic          w_bit;
        logic [VW-1:0] n_rem;

        if (s == 0) begin : g_first
            assign w_vld_in  = i_valid;
            assign w_side_in = i_side;
            assign w_dvs_in  = i_dvs;
            assign w_rem_in  = '0;
            assign w_dq_in   = i_dvd;
        end else begin : g_next
            assign w_vld_in  = r_vld[s-1];
            assign w_side_in = r_side[s-1];
            assign w_dvs_in  = r_dvs[s-1];
            assign w_rem_in  = r_rem[s-1];
            assign w_dq_in   = r_dq[s-1];
        end

        assign w_t   = {w_rem_in, w_dq_in[DW-1]};
        assign w_d   = w_t - {1'b0, w_dvs_in};
        assign w_bit = !w_d[VW];
        assign n_rem = w_bit ? w_d[VW-1:0] : w_t[VW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_dq[s]   <= {w_dq_in[DW-2:0], w_bit};
                r_dvs[s]  <= w_dvs_in;
                r_side[s] <= w_side_in;
            end
        end
    end

    assign o_valid = r_vld[DW-1];
    assign o_side  = r_side[DW-1];
    assign o_quo   = r_dq[DW-1];

endmodule

@@ rtl/core/encoder_angle_decoder_top.sv @@
// Encoder angle decoder top: input stage, operand prep, divider, calibration.
// One item per cycle while no result waits at the output;
// the divider pipeline, one quotient bit per stage, sets the depth.
// The whole pipeline holds while a result waits at the output.
// Synchronous active-low reset clears valid bits, config registers and held speed.
// Depends on ead_pkg, ead_div and assert_macros.svh.
`include "assert_macros.svh"
module encoder_angle_decoder_top #(
    parameter int ANGLE_FRAC_BITS = ead_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_pulse_on,
    input  logic signed [15:0] i_pulse_period,
    input  logic [15:0]        i_rollover_count,
    input  logic [7:0]         i_error_code,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_angle_deg,
    output logic signed [29:0] o_speed,
    output logic [7:0]         o_sensor_error
);
    import ead_pkg::*;

    localparam int DW  = CNT_W + ANGLE_FRAC_BITS;
    localparam int HW  = DW - 32;
    localparam int HPW = HW + GAIN_W;
    localparam int LPW = 32 + GAIN_W;
    localparam int QW  = CNT_W + 1;
    localparam int SW  = QW + 2;

    // configuration
    t_mode                     r_mode;
    logic signed [GAIN_W-1:0]  r_gain;
    logic signed [31:0]        r_offset;
    logic [DVS_W-1:0]          r_tpr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_QUAD;
            r_gain   <= GAIN_W'(65536);
            r_offset <= '0;
            r_tpr    <= DVS_W'(8192);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MODE:   r_mode   <= t_mode'(i_cfg_data[1:0]);
                REG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_OFFSET: r_offset <= i_cfg_data;
                REG_TPR:    r_tpr    <= i_cfg_data[DVS_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic accept;
    logic r_out_valid;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign accept     = i_in_valid && en;

    // input stage and held speed
    logic signed [30:0]        w_spd_full;
    logic signed [SPEED_W-1:0] w_speed_new;
    logic signed [SPEED_W-1:0] r_held;
    logic                      r0_vld;
    logic [15:0]               r0_on;
    logic signed [15:0]        r0_per;
    logic [15:0]               r0_roll;
    logic signed [SPEED_W-1:0] r0_speed;
    logic [7:0]                r0_err;

    assign w_spd_full  = 31'(i_pulse_period) * 31'(SPEED_K);
    assign w_speed_new = w_spd_full[SPEED_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r_held <= '0;
        end else if (en) begin
            r0_vld <= i_in_valid;
            if (accept && r_mode == MODE_QUAD) begin
                r_held <= w_speed_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_on    <= i_pulse_on;
            r0_per   <= i_pulse_period;
            r0_roll  <= i_rollover_count;
            r0_speed <= (r_mode == MODE_QUAD) ? w_speed_new : r_held;
            r0_err   <= (r_mode == MODE_ABS14) ? i_error_code : 8'd0;
        end
    end

    // operand prep
    logic [31:0]       w_ticks;
    logic [31:0]       w_tm;
    logic [28:0]       w_prod;
    logic signed [30:0] w_diff;
    logic [29:0]       w_nm;
    logic [15:0]       w_pm;
    logic [CNT_W-1:0]  w_num;
    logic [DVS_W-1:0]  w_dvs;
    t_side             w_side;

    assign w_ticks = {r0_roll, r0_on};
    assign w_tm    = w_ticks[31] ? (~w_ticks + 32'd1) : w_ticks;
    assign w_prod  = 29'(r0_on) * ((r_mode == MODE_PWM12) ? 29'(K_PWM12) : 29'(K_PWM10));
    assign w_diff  = $signed({2'b00, w_prod}) - 31'(r0_per);
    assign w_nm    = w_diff[30] ? 30'(-w_diff) : w_diff[29:0];
    assign w_pm    = r0_per[15] ? 16'(-r0_per) : r0_per;

    always_comb begin
        w_side       = '0;
        w_side.speed = r0_speed;
        w_side.err   = r0_err;
        case (r_mode)
            MODE_QUAD: begin
                w_num       = CNT_W'(CNT_W'(w_tm) * CNT_W'(DEG_TURN));
                w_dvs       = r_tpr;
                w_side.neg  = w_ticks[31];
                w_side.zmag = (r_tpr == '0);
            end
            MODE_ABS14: begin
                w_num = CNT_W'(CNT_W'(r0_on) * CNT_W'(DEG_TURN));
                w_dvs = DVS_W'(ABS_DIV);
            end
            default: begin
                w_num         = CNT_W'(CNT_W'(w_nm) * CNT_W'(DEG_TURN));
                w_dvs         = (r_mode == MODE_PWM12) ? (DVS_W'(w_pm) << SH_PWM12)
                                                       : (DVS_W'(w_pm) << SH_PWM10);
                w_side.neg    = w_diff[30] ^ r0_per[15];
                w_side.bypass = (r0_per == '0);
            end
        endcase
    end

    logic             r1_vld;
    logic [DW-1:0]    r1_dvd;
    logic [DVS_W-1:0] r1_dvs;
    t_side            r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dvd  <= {w_num, {ANGLE_FRAC_BITS{1'b0}}};
            r1_dvs  <= w_dvs;
            r1_side <= w_side;
        end
    end

    // divider
    logic          w_dv_vld;
    t_side         w_dv_side;
    logic [DW-1:0] w_quo;

    ead_div #(
        .DW (DW),
        .VW (DVS_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_vld),
        .i_side  (r1_side),
        .i_dvd   (r1_dvd),
        .i_dvs   (r1_dvs),
        .o_valid (w_dv_vld),
        .o_side  (w_dv_side),
        .o_quo   (w_quo)
    );

    // calibration: products
    logic [DW-1:0]     w_mag;
    logic [GAIN_W-1:0] w_gm;
    logic              r2_vld;
    logic [HPW-1:0]    r2_hi;
    logic [LPW-1:0]    r2_lo;
    logic              r2_sneg;
    t_side             r2_side;

    assign w_mag = w_dv_side.zmag ? '0 : w_quo;
    assign w_gm  = r_gain[GAIN_W-1] ? GAIN_W'(-r_gain) : r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_hi   <= HPW'(w_mag[DW-1:32]) * HPW'(w_gm);
            r2_lo   <= LPW'(w_mag[31:0]) * LPW'(w_gm);
            r2_sneg <= w_dv_side.neg ^ r_gain[GAIN_W-1];
            r2_side <= w_dv_side;
        end
    end

    // calibration: sum with offset
    logic [QW-1:0]        w_q;
    logic signed [SW-1:0] w_qs;
    logic signed [SW-1:0] w_sum;
    logic                 r3_vld;
    logic signed [SW-1:0] r3_sum;
    logic                 r3_sat;
    logic                 r3_sneg;
    t_side                r3_side;

    assign w_q   = QW'({r2_hi[14:0], 16'd0}) + QW'(r2_lo[LPW-1:16]);
    assign w_qs  = $signed({2'b00, w_q});
    assign w_sum = (r2_sneg ? -w_qs : w_qs) + SW'(r_offset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sum  <= w_sum;
            r3_sat  <= (r2_hi >= HPW'(HI_LIM));
            r3_sneg <= r2_sneg;
            r3_side <= r2_side;
        end
    end

    // saturation and output register
    logic signed [31:0] w_ang;

    always_comb begin
        if (r3_side.bypass) begin
            w_ang = '0;
        end else if (r3_sat) begin
            w_ang = r3_sneg ? ANG_MIN : ANG_MAX;
        end else if (r3_sum[SW-1:31] != {(SW-31){r3_sum[SW-1]}}) begin
            w_ang = r3_sum[SW-1] ? ANG_MIN : ANG_MAX;
        end else begin
            w_ang = r3_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_angle_deg    <= w_ang;
            o_speed        <= r3_side.speed;
            o_sensor_error <= r3_side.err;
        end
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_NEXT(a_bypass_zero, i_clk, i_rst_n, r3_vld && r3_side.bypass && en, o_angle_deg == 0)
    `ASSERT_SAME(a_err_abs_only, i_clk, i_rst_n, o_out_valid && o_sensor_error != 0, r_mode == MODE_ABS14)
    `ASSERT_NEXT(a_held_quad, i_clk, i_rst_n, accept && r_mode == MODE_QUAD, r_held == $past(w_speed_new))

endmodule
